>>> sv/assert_macros.svh
// Assertion macros shared by the register writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is held.
`define L3W_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define L3W_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/l3w_pkg.sv
// Types, constants and encoding functions for the L3 register writer.
package l3w_pkg;

  localparam int unsigned NUM_REGS = 12;
  localparam logic [5:0] DEV_ADDR_RST = 6'd5;
  localparam logic [7:0] EXT_ADDR_PREFIX = 8'hC0;
  localparam logic [7:0] EXT_DATA_PREFIX = 8'hE0;
  localparam logic [1:0] TYPE_DATA0 = 2'd0;
  localparam logic [1:0] TYPE_DATA1 = 2'd1;
  localparam logic [1:0] TYPE_STATUS = 2'd2;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic [4:0] CNT_EXT = 5'd31;  // 32 bits, two address/data pairs
  localparam logic [4:0] CNT_STD = 5'd15;  // 16 bits, one pair

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_SHIFT
  } l3w_state_t;

  // sequencer -> shift unit
  typedef struct packed {
    logic       load;
    logic       shift;
    logic [7:0] load_byte;
  } l3w_shctl_t;

  // sequencer -> top status
  typedef struct packed {
    logic busy;
    logic single;
    logic bits;
    logic bad;
    logic last;
    logic byte_end;
    logic mode;
  } l3w_stat_t;

  function automatic logic [7:0] reset_val(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd1:                v = 8'h40;
      4'd2:                v = 8'h80;
      4'd3, 4'd4, 4'd5:    v = 8'h04;
      4'd11:               v = 8'h83;
      default:             v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] marker(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd1:         v = 8'h40;
      4'd2, 4'd11:  v = 8'h80;
      default:      v = 8'h00;
    endcase
    return v;
  endfunction

  // extended register code for cache index 3..8
  function automatic logic [7:0] ext_code(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd4:    v = 8'd1;
      4'd5:    v = 8'd2;
      4'd6:    v = 8'd4;
      4'd7:    v = 8'd5;
      4'd8:    v = 8'd6;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/l3w_shift.sv
// Shared 8-bit shift unit: loads a byte, then moves it out LSB first.
module l3w_shift (
  input  logic                clk,
  input  l3w_pkg::l3w_shctl_t ctl,
  output logic                bit_out
);

  logic [7:0] sh_r;
  logic [7:0] sh_nxt;

  always_comb begin
    sh_nxt = sh_r;
    if (ctl.load) begin
      sh_nxt = ctl.load_byte;
    end else if (ctl.shift) begin
      sh_nxt = {1'b0, sh_r[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign bit_out = sh_r[0];

endmodule

>>> sv/l3w_seq.sv
// Sequencer: bit counter, byte selection and result framing.
module l3w_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                opcode,
  input  logic [3:0]          reg_idx,
  input  logic [7:0]          value,
  input  logic [5:0]          dev_addr,
  output l3w_pkg::l3w_shctl_t shctl,
  output l3w_pkg::l3w_stat_t  stat
);

  l3w_pkg::l3w_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [4:0] cnt_dec;
  logic       ext_r, bad_r;
  logic [7:0] addr_r, xa_r, dat_r;
  logic       accept, bad_in, ext_in;
  logic [1:0] type_in;
  logic [7:0] next_byte;

  assign accept  = start && (state_r == l3w_pkg::ST_IDLE);
  assign bad_in  = (reg_idx >= 4'(l3w_pkg::NUM_REGS));
  assign ext_in  = reg_idx inside {[4'd3:4'd8]};
  assign cnt_dec = cnt_r - 5'd1;

  always_comb begin
    if (reg_idx >= 4'd10) begin
      type_in = l3w_pkg::TYPE_STATUS;
    end else if (reg_idx == 4'd9) begin
      type_in = l3w_pkg::TYPE_DATA1;
    end else begin
      type_in = l3w_pkg::TYPE_DATA0;
    end
  end

  // byte of the next bit count: odd byte slot (cnt[3] set) is an address byte
  always_comb begin
    if (cnt_dec[3]) begin
      next_byte = addr_r;
    end else if (ext_r && cnt_dec[4:3] == 2'b10) begin
      next_byte = xa_r;
    end else begin
      next_byte = dat_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      l3w_pkg::ST_IDLE: begin
        if (start) begin
          if (bad_in || opcode == l3w_pkg::OP_READ) begin
            state_nxt = l3w_pkg::ST_SINGLE;
          end else begin
            state_nxt = l3w_pkg::ST_SHIFT;
            cnt_nxt   = ext_in ? l3w_pkg::CNT_EXT : l3w_pkg::CNT_STD;
          end
        end
      end
      l3w_pkg::ST_SINGLE: state_nxt = l3w_pkg::ST_IDLE;
      l3w_pkg::ST_SHIFT: begin
        if (cnt_r == 5'd0) begin
          state_nxt = l3w_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_dec;
        end
      end
      default: state_nxt = l3w_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    shctl          = '0;
    stat           = '0;
    stat.busy      = (state_r != l3w_pkg::ST_IDLE);
    stat.bad       = bad_r;
    case (state_r)
      l3w_pkg::ST_IDLE: begin
        shctl.load      = accept;
        shctl.load_byte = {dev_addr, type_in};
      end
      l3w_pkg::ST_SINGLE: begin
        stat.single = 1'b1;
        stat.last   = 1'b1;
      end
      l3w_pkg::ST_SHIFT: begin
        stat.bits     = 1'b1;
        stat.last     = (cnt_r == 5'd0);
        stat.byte_end = (cnt_r[2:0] == 3'd0);
        stat.mode     = ~cnt_r[3];
        if (cnt_r != 5'd0) begin
          shctl.load      = (cnt_r[2:0] == 3'd0);
          shctl.shift     = (cnt_r[2:0] != 3'd0);
          shctl.load_byte = next_byte;
        end
      end
      default: begin
        stat.busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= l3w_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // extended registers decode as data0, so their address byte is the data0 one
  always_ff @(posedge clk) begin
    if (accept) begin
      bad_r  <= bad_in;
      ext_r  <= ext_in;
      addr_r <= {dev_addr, type_in};
      xa_r   <= l3w_pkg::EXT_ADDR_PREFIX | l3w_pkg::ext_code(reg_idx);
      dat_r  <= value | l3w_pkg::marker(reg_idx) |
                (ext_in ? l3w_pkg::EXT_DATA_PREFIX : 8'h00);
    end
  end

endmodule

>>> sv/l3_bus_codec_register_writer_top.sv
// Top level of the L3-bus codec register writer.
//
// Usage:
//   Command channel: an item transfers when start is high and busy is low.
//   in_opcode 0 writes in_write_value into cache entry in_register_index and
//   sends it over the L3 bus; 1 reads the cached byte back.
//   Results: one per cycle while out_valid is high, taken on that cycle's
//   closing edge. The receiver cannot hold them off, so no stall path exists.
//   A write emits one bus bit per result, LSB first: address byte with mode
//   low, data byte with mode high. Extended registers (index 3..8) send two
//   pairs through the data0 address, 32 bits; other writes send 16 bits.
//   Reads and bad indexes (12 or more) give one result.
//   The first result appears in the cycle after the transfer. A new command is
//   taken only once the last result of the previous one is out (busy is high
//   until then), as set by the single shift unit and its 5-bit bit counter.
//   Config: cfg_device_address transfers on cfg_valid and cfg_ready; ready
//   is high whenever the block is idle.
//   Reset (rst_n low, synchronous) loads the cache defaults, device address 5,
//   and leaves the block idle.
`include "assert_macros.svh"

module l3_bus_codec_register_writer_top (
  input  logic       clk,
  input  logic       rst_n,
  // command channel
  input  logic       start,
  output logic       busy,
  input  logic       in_opcode,
  input  logic [3:0] in_register_index,
  input  logic [7:0] in_write_value,
  // result channel
  output logic       out_valid,
  output logic       out_mode_level,
  output logic       out_data_bit,
  output logic       out_byte_end,
  output logic [7:0] out_read_byte,
  output logic       out_is_bit,
  output logic       out_bad_index,
  output logic       out_last,
  // config channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_device_address
);

  logic [7:0]          cache_r [0:l3w_pkg::NUM_REGS-1];
  logic [5:0]          dev_addr_r;
  logic [7:0]          rd_r;
  logic                accept;
  logic                idx_ok;
  l3w_pkg::l3w_shctl_t shctl;
  l3w_pkg::l3w_stat_t  stat;
  logic                sh_bit;

  assign accept = start && !stat.busy;
  assign idx_ok = (in_register_index < 4'(l3w_pkg::NUM_REGS));

  l3w_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .opcode   (in_opcode),
    .reg_idx  (in_register_index),
    .value    (in_write_value),
    .dev_addr (dev_addr_r),
    .shctl    (shctl),
    .stat     (stat)
  );

  l3w_shift u_shift (
    .clk     (clk),
    .ctl     (shctl),
    .bit_out (sh_bit)
  );

  // config register; host writes only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= l3w_pkg::DEV_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_device_address;
    end
  end

  // register cache, reset to the codec defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < l3w_pkg::NUM_REGS; i++) begin
        cache_r[i] <= l3w_pkg::reset_val(4'(i));
      end
    end else if (accept && idx_ok && in_opcode == l3w_pkg::OP_WRITE) begin
      cache_r[in_register_index] <= in_write_value;
    end
  end

  // read data captured at transfer; zero on a bad index
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= idx_ok ? cache_r[in_register_index] : 8'h00;
    end
  end

  assign busy           = stat.busy;
  assign cfg_ready      = !stat.busy;
  assign out_valid      = stat.single || stat.bits;
  assign out_mode_level = stat.mode;
  assign out_data_bit   = stat.bits && sh_bit;
  assign out_byte_end   = stat.byte_end;
  assign out_read_byte  = (stat.single && !stat.bad) ? rd_r : 8'h00;
  assign out_is_bit     = stat.bits;
  assign out_bad_index  = stat.single && stat.bad;
  assign out_last       = stat.last;

  // every transferred command shows its first result on the next cycle
  `L3W_ASSERT(a_first_result, (start && !busy) |=> out_valid, "no result after command")
  // the final result frees the block
  `L3W_ASSERT(a_last_frees, (out_valid && out_last) |=> !busy, "busy after last result")
  // a bit stream runs without gaps until its last bit
  `L3W_ASSERT(a_bits_cont, (out_is_bit && !out_last) |=> out_is_bit, "gap in bit stream")
  // the last bit of a stream falls on a data byte boundary
  `L3W_ASSERT(a_last_on_end, (out_is_bit && out_last) |-> (out_byte_end && out_mode_level),
    "stream ends off a data byte boundary")

endmodule
